>>> rtl/jft_pkg.sv
package jft_pkg;

    localparam int IO_W      = 24;
    localparam int ROT_W     = 18;
    localparam int POS_W     = 21;
    localparam int ROW_W     = 3 * ROT_W;
    localparam int POS_VEC_W = 3 * POS_W;
    localparam int CFG_W     = POS_VEC_W;
    localparam int CFG_IDX_W = 3;
    localparam int DATA_W    = 6 * IO_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_SELECT = 3'd0,
        CFG_ROT_ROW0     = 3'd1,
        CFG_ROT_ROW1     = 3'd2,
        CFG_ROT_ROW2     = 3'd3,
        CFG_BODY_POS     = 3'd4,
        CFG_REF_POS      = 3'd5
    } cfg_idx_t;

    typedef logic signed [IO_W-1:0]  io_t;
    typedef logic signed [ROT_W-1:0] rot_t;

    // Identity rotation at reset: a one on the diagonal of each row.
    localparam logic [ROW_W-1:0] ROT_ROW0_RST = 54'd65536;
    localparam logic [ROW_W-1:0] ROT_ROW1_RST = 54'd17179869184;
    localparam logic [ROW_W-1:0] ROT_ROW2_RST = 54'd4503599627370496;

    localparam longint OUT_MAX = 64'sd8388607;
    localparam longint OUT_MIN = -64'sd8388608;

endpackage

>>> rtl/jacobian_frame_transform_top.sv
// Jacobian column frame change.
// Each item on the s_axis channel is one column of a world-frame Jacobian:
// three linear and three angular entries in tdata, the last-column flag in
// tlast. With frame_select set, the block returns the column expressed in
// the reference frame (linear = R^T(v - w x (body_pos - ref_pos)),
// angular = R^T w), saturated to 24 bits; with frame_select clear the column
// passes through unchanged. Each item gives exactly one item on m_axis.
// The configuration port writes one register per cycle on cfg_we; the user
// must make writes only while no item is in flight; the block does not enforce it.
// The datapath is a four-stage pipeline: cross and rotation products,
// cross difference with the angular sums, linear rotation products, and
// the linear sums with saturation. An accepted item passes through the s1,
// s2, s3 and output registers in order before m_axis_tvalid rises, and while
// m_axis_tready does not stall the output, one item is taken every cycle.
// When m_axis_tready is low, the output item holds and the stages behind it
// keep filling their empty slots; s_axis_tready drops only when all four
// stages are full. Reset empties the pipeline, selects pass-through, loads
// the identity rotation and clears both positions.
module jacobian_frame_transform_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // lin_x, lin_y, lin_z, ang_x, ang_y, ang_z
    input  logic [jft_pkg::DATA_W-1:0]    s_axis_tdata,
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_lin_x, out_lin_y, out_lin_z, out_ang_x, out_ang_y, out_ang_z
    output logic [jft_pkg::DATA_W-1:0]    m_axis_tdata,
    output logic                          m_axis_tlast,
    input  logic                          cfg_we,
    input  logic [jft_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [jft_pkg::CFG_W-1:0]     cfg_data
);

    localparam int IO_W    = jft_pkg::IO_W;
    localparam int ROT_W   = jft_pkg::ROT_W;
    localparam int POS_W   = jft_pkg::POS_W;
    localparam int D_W     = POS_W + 1;
    localparam int PROD_W  = IO_W + D_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int CR_W    = CROSS_W - FRAC_BITS;
    localparam int U_W     = ((CR_W > IO_W) ? CR_W : IO_W) + 1;
    localparam int LP_W    = ROT_W + U_W;
    localparam int LS_W    = LP_W + 2;
    localparam int LSH_W   = LS_W - FRAC_BITS;
    localparam int AP_W    = ROT_W + IO_W;
    localparam int AS_W    = AP_W + 2;
    localparam int ASH_W   = AS_W - FRAC_BITS;

    localparam logic signed [LSH_W-1:0] LIN_HI = LSH_W'(jft_pkg::OUT_MAX);
    localparam logic signed [LSH_W-1:0] LIN_LO = LSH_W'(jft_pkg::OUT_MIN);
    localparam logic signed [ASH_W-1:0] ANG_HI = ASH_W'(jft_pkg::OUT_MAX);
    localparam logic signed [ASH_W-1:0] ANG_LO = ASH_W'(jft_pkg::OUT_MIN);
    localparam logic signed [IO_W-1:0]  SAT_HI = IO_W'(jft_pkg::OUT_MAX);
    localparam logic signed [IO_W-1:0]  SAT_LO = IO_W'(jft_pkg::OUT_MIN);

    // Configuration registers.
    logic                            frame_sel_reg;
    logic [jft_pkg::ROW_W-1:0]       rot_row_reg [3];
    logic [jft_pkg::POS_VEC_W-1:0]   body_pos_reg;
    logic [jft_pkg::POS_VEC_W-1:0]   ref_pos_reg;

    // Pipeline handshake.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic s1_ready, s2_ready, s3_ready, out_ready;

    // Stage payloads.
    jft_pkg::io_t               s1_v_reg  [3];
    jft_pkg::io_t               s1_w_reg  [3];
    logic signed [PROD_W-1:0]   s1_cp_reg [3][2];
    logic signed [AP_W-1:0]     s1_ap_reg [3][3];
    logic                       s1_last_reg, s1_sel_reg;

    jft_pkg::io_t               s2_v_reg   [3];
    jft_pkg::io_t               s2_w_reg   [3];
    logic signed [U_W-1:0]      s2_u_reg   [3];
    jft_pkg::io_t               s2_ang_reg [3];
    logic                       s2_last_reg, s2_sel_reg;

    jft_pkg::io_t               s3_v_reg   [3];
    jft_pkg::io_t               s3_w_reg   [3];
    logic signed [LP_W-1:0]     s3_lp_reg  [3][3];
    jft_pkg::io_t               s3_ang_reg [3];
    logic                       s3_last_reg, s3_sel_reg;

    logic [jft_pkg::DATA_W-1:0] out_data_reg;
    logic                       out_last_reg;

    // Combinational next values.
    jft_pkg::io_t               in_v [3];
    jft_pkg::io_t               in_w [3];
    jft_pkg::rot_t              rot  [3][3];
    logic signed [D_W-1:0]      dpos [3];
    logic signed [PROD_W-1:0]   cp_next [3][2];
    logic signed [AP_W-1:0]     ap_next [3][3];
    logic signed [U_W-1:0]      u_next   [3];
    jft_pkg::io_t               ang_next [3];
    logic signed [LP_W-1:0]     lp_next  [3][3];
    logic [jft_pkg::DATA_W-1:0] out_data_next;

    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign s3_ready      = !s3_valid_reg || out_ready;
    assign s2_ready      = !s2_valid_reg || s3_ready;
    assign s1_ready      = !s1_valid_reg || s2_ready;
    assign s_axis_tready = s1_ready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_sel_reg  <= 1'b0;
            rot_row_reg[0] <= jft_pkg::ROT_ROW0_RST;
            rot_row_reg[1] <= jft_pkg::ROT_ROW1_RST;
            rot_row_reg[2] <= jft_pkg::ROT_ROW2_RST;
            body_pos_reg   <= '0;
            ref_pos_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (jft_pkg::cfg_idx_t'(cfg_index))
                jft_pkg::CFG_FRAME_SELECT: frame_sel_reg  <= cfg_data[0];
                jft_pkg::CFG_ROT_ROW0:     rot_row_reg[0] <= cfg_data[jft_pkg::ROW_W-1:0];
                jft_pkg::CFG_ROT_ROW1:     rot_row_reg[1] <= cfg_data[jft_pkg::ROW_W-1:0];
                jft_pkg::CFG_ROT_ROW2:     rot_row_reg[2] <= cfg_data[jft_pkg::ROW_W-1:0];
                jft_pkg::CFG_BODY_POS:     body_pos_reg   <= cfg_data[jft_pkg::POS_VEC_W-1:0];
                jft_pkg::CFG_REF_POS:      ref_pos_reg    <= cfg_data[jft_pkg::POS_VEC_W-1:0];
                default:                   ;
            endcase
        end
    end

    // Stage 1: lever arm, cross products and angular rotation products.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            in_v[i] = $signed(s_axis_tdata[IO_W*i +: IO_W]);
            in_w[i] = $signed(s_axis_tdata[IO_W*(i+3) +: IO_W]);
            dpos[i] = D_W'($signed(body_pos_reg[POS_W*i +: POS_W]))
                    - D_W'($signed(ref_pos_reg[POS_W*i +: POS_W]));
            for (int c = 0; c < 3; c++)
            begin
                rot[i][c] = $signed(rot_row_reg[i][ROT_W*c +: ROT_W]);
            end
        end
        cp_next[0][0] = PROD_W'(in_w[1]) * PROD_W'(dpos[2]);
        cp_next[0][1] = PROD_W'(in_w[2]) * PROD_W'(dpos[1]);
        cp_next[1][0] = PROD_W'(in_w[2]) * PROD_W'(dpos[0]);
        cp_next[1][1] = PROD_W'(in_w[0]) * PROD_W'(dpos[2]);
        cp_next[2][0] = PROD_W'(in_w[0]) * PROD_W'(dpos[1]);
        cp_next[2][1] = PROD_W'(in_w[1]) * PROD_W'(dpos[0]);
        for (int i = 0; i < 3; i++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                ap_next[i][r] = AP_W'(rot[r][i]) * AP_W'(in_w[r]);
            end
        end
    end

    // Stage 2: cross difference subtracted from v, and the angular sums with saturation.
    always_comb
    begin
        logic signed [CROSS_W-1:0] cross_full;
        logic signed [CR_W-1:0]    cr;
        logic signed [AS_W-1:0]    asum;
        logic signed [ASH_W-1:0]   ash;
        for (int i = 0; i < 3; i++)
        begin
            cross_full = CROSS_W'(s1_cp_reg[i][0]) - CROSS_W'(s1_cp_reg[i][1]);
            cr         = CR_W'(cross_full >>> FRAC_BITS);
            u_next[i]  = U_W'(s1_v_reg[i]) - U_W'(cr);
            asum       = AS_W'(s1_ap_reg[i][0]) + AS_W'(s1_ap_reg[i][1])
                       + AS_W'(s1_ap_reg[i][2]);
            ash        = ASH_W'(asum >>> FRAC_BITS);
            if (ash > ANG_HI)
            begin
                ang_next[i] = SAT_HI;
            end
            else if (ash < ANG_LO)
            begin
                ang_next[i] = SAT_LO;
            end
            else
            begin
                ang_next[i] = IO_W'(ash);
            end
        end
    end

    // Stage 3: linear rotation products.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                lp_next[i][r] = LP_W'(rot[r][i]) * LP_W'(s2_u_reg[r]);
            end
        end
    end

    // Stage 4: linear sums, saturation and the pass-through select.
    always_comb
    begin
        logic signed [LS_W-1:0]  lsum;
        logic signed [LSH_W-1:0] lsh;
        jft_pkg::io_t            lin;
        for (int i = 0; i < 3; i++)
        begin
            lsum = LS_W'(s3_lp_reg[i][0]) + LS_W'(s3_lp_reg[i][1]) + LS_W'(s3_lp_reg[i][2]);
            lsh  = LSH_W'(lsum >>> FRAC_BITS);
            if (lsh > LIN_HI)
            begin
                lin = SAT_HI;
            end
            else if (lsh < LIN_LO)
            begin
                lin = SAT_LO;
            end
            else
            begin
                lin = IO_W'(lsh);
            end
            out_data_next[IO_W*i +: IO_W]     = s3_sel_reg ? lin : s3_v_reg[i];
            out_data_next[IO_W*(i+3) +: IO_W] = s3_sel_reg ? s3_ang_reg[i] : s3_w_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_v_reg    <= in_v;
            s1_w_reg    <= in_w;
            s1_cp_reg   <= cp_next;
            s1_ap_reg   <= ap_next;
            s1_last_reg <= s_axis_tlast;
            s1_sel_reg  <= frame_sel_reg;
        end
        if (s2_ready)
        begin
            s2_v_reg    <= s1_v_reg;
            s2_w_reg    <= s1_w_reg;
            s2_u_reg    <= u_next;
            s2_ang_reg  <= ang_next;
            s2_last_reg <= s1_last_reg;
            s2_sel_reg  <= s1_sel_reg;
        end
        if (s3_ready)
        begin
            s3_v_reg    <= s2_v_reg;
            s3_w_reg    <= s2_w_reg;
            s3_lp_reg   <= lp_next;
            s3_ang_reg  <= s2_ang_reg;
            s3_last_reg <= s2_last_reg;
            s3_sel_reg  <= s2_sel_reg;
        end
        if (out_ready)
        begin
            out_data_reg <= out_data_next;
            out_last_reg <= s3_last_reg;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg
                            && out_valid_reg && !m_axis_tready))
        else $error("input stalled while the pipeline has a free slot");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && !(m_axis_tvalid && m_axis_tready))
        |=> ($countones({s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg})
             == $past($countones({s1_valid_reg, s2_valid_reg, s3_valid_reg,
                                  out_valid_reg})) + 1))
        else $error("accepted item not held in the pipeline");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!(s_axis_tvalid && s_axis_tready) && m_axis_tvalid && m_axis_tready)
        |=> ($countones({s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg})
             == $past($countones({s1_valid_reg, s2_valid_reg, s3_valid_reg,
                                  out_valid_reg})) - 1))
        else $error("delivered item not removed from the pipeline");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

typedef struct packed {
    logic                       last;
    logic [jft_pkg::DATA_W-1:0] data;
} column_t;

class column_scoreboard #(int FRAC_BITS = 16);

    logic                          frame_sel;
    logic [jft_pkg::ROW_W-1:0]     rot_q[3];
    logic [jft_pkg::POS_VEC_W-1:0] body_q;
    logic [jft_pkg::POS_VEC_W-1:0] origin_q;
    column_t                       expected_cols[$];
    string                         field_name[6];
    int                            errors;
    int                            checked;

    function new();
        frame_sel = 1'b0;
        rot_q[0] = jft_pkg::ROT_ROW0_RST;
        rot_q[1] = jft_pkg::ROT_ROW1_RST;
        rot_q[2] = jft_pkg::ROT_ROW2_RST;
        body_q = '0;
        origin_q = '0;
        field_name = '{"lin_x", "lin_y", "lin_z", "ang_x", "ang_y", "ang_z"};
        errors = 0;
        checked = 0;
    endfunction

    function void apply_config(logic [jft_pkg::CFG_IDX_W-1:0] idx,
                               logic [jft_pkg::CFG_W-1:0] val);
        case (idx)
            jft_pkg::CFG_FRAME_SELECT: frame_sel = val[0];
            jft_pkg::CFG_ROT_ROW0:     rot_q[0] = val[jft_pkg::ROW_W-1:0];
            jft_pkg::CFG_ROT_ROW1:     rot_q[1] = val[jft_pkg::ROW_W-1:0];
            jft_pkg::CFG_ROT_ROW2:     rot_q[2] = val[jft_pkg::ROW_W-1:0];
            jft_pkg::CFG_BODY_POS:     body_q = val[jft_pkg::POS_VEC_W-1:0];
            jft_pkg::CFG_REF_POS:      origin_q = val[jft_pkg::POS_VEC_W-1:0];
            default: ;
        endcase
    endfunction

    function jft_pkg::io_t clamp(longint x);
        if (x > jft_pkg::OUT_MAX)
            return jft_pkg::io_t'(jft_pkg::OUT_MAX);
        if (x < jft_pkg::OUT_MIN)
            return jft_pkg::io_t'(jft_pkg::OUT_MIN);
        return jft_pkg::io_t'(x);
    endfunction

    function longint rot_entry(int r, int c);
        return longint'(jft_pkg::rot_t'(rot_q[r][c*jft_pkg::ROT_W +: jft_pkg::ROT_W]));
    endfunction

    function column_t to_reference_frame(column_t col);
        column_t res;
        longint  v[3];
        longint  w[3];
        longint  d[3];
        longint  u[3];
        longint  acc_lin;
        longint  acc_ang;
        int      i;
        int      j;
        int      k;
        int      r;
        res = col;
        if (!frame_sel)
            return res;
        for (i = 0; i < 3; i++) begin
            v[i] = longint'(jft_pkg::io_t'(col.data[i*jft_pkg::IO_W +: jft_pkg::IO_W]));
            w[i] = longint'(jft_pkg::io_t'(col.data[(i+3)*jft_pkg::IO_W +: jft_pkg::IO_W]));
            d[i] = longint'($signed(body_q[i*jft_pkg::POS_W +: jft_pkg::POS_W]))
                 - longint'($signed(origin_q[i*jft_pkg::POS_W +: jft_pkg::POS_W]));
        end
        for (i = 0; i < 3; i++) begin
            j = (i + 1) % 3;
            k = (i + 2) % 3;
            u[i] = v[i] - ((w[j] * d[k] - w[k] * d[j]) >>> FRAC_BITS);
        end
        for (i = 0; i < 3; i++) begin
            acc_lin = 0;
            acc_ang = 0;
            for (r = 0; r < 3; r++) begin
                acc_lin += rot_entry(r, i) * u[r];
                acc_ang += rot_entry(r, i) * w[r];
            end
            res.data[i*jft_pkg::IO_W +: jft_pkg::IO_W] = clamp(acc_lin >>> FRAC_BITS);
            res.data[(i+3)*jft_pkg::IO_W +: jft_pkg::IO_W] = clamp(acc_ang >>> FRAC_BITS);
        end
        return res;
    endfunction

    function void note_column(column_t col);
        expected_cols.push_back(to_reference_frame(col));
    endfunction

    function int pending();
        return expected_cols.size();
    endfunction

    task report(string msg);
        if (errors < 100)
            $display("MISMATCH %s", msg);
        errors++;
    endtask

    task check_result(column_t got);
        column_t     want;
        jft_pkg::io_t got_f;
        jft_pkg::io_t want_f;
        int          f;
        if (expected_cols.size() == 0) begin
            report($sformatf("output item %0d arrived with nothing expected", checked));
            checked++;
            return;
        end
        want = expected_cols.pop_front();
        for (f = 0; f < 6; f++) begin
            got_f = got.data[f*jft_pkg::IO_W +: jft_pkg::IO_W];
            want_f = want.data[f*jft_pkg::IO_W +: jft_pkg::IO_W];
            if (got_f !== want_f)
                report($sformatf("item %0d %s: got %0d, want %0d",
                                 checked, field_name[f], got_f, want_f));
        end
        if (got.last !== want.last)
            report($sformatf("item %0d last: got %b, want %b", checked, got.last, want.last));
        checked++;
    endtask

endclass

module tb_top;

    import jft_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam int HOLD_AT       = 600;
    localparam int HOLD_CYCLES   = 150;
    localparam int SETTLE_CYCLES = 8;
    localparam int SMALL_SPAN    = 1 << 18;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    // lin_x, lin_y, lin_z, ang_x, ang_y, ang_z
    logic [DATA_W-1:0]    s_axis_tdata;
    logic                 s_axis_tlast;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // out_lin_x, out_lin_y, out_lin_z, out_ang_x, out_ang_y, out_ang_z
    logic [DATA_W-1:0]    m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    column_scoreboard #(FRAC_BITS) sb;

    bit idle_on;
    int idle_pct;
    int sent_count;
    bit rx_hold;

    jacobian_frame_transform_top #(
        .FRAC_BITS(FRAC_BITS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("tb_top: errors");
        $finish;
    end

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.apply_config(idx, val);
    endtask

    task send_column(column_t col);
        if (idle_on && $urandom_range(0, 99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= col.data;
        s_axis_tlast <= col.last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_column(col);
        sent_count++;
    endtask

    task settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function logic [IO_W-1:0] rand_entry();
        int sel;
        int s;
        sel = $urandom_range(0, 9);
        s = int'($urandom_range(0, 2 * SMALL_SPAN)) - SMALL_SPAN;
        case (sel)
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2, 3, 4: return IO_W'($urandom());
            default: return s[IO_W-1:0];
        endcase
    endfunction

    function column_t rand_column(logic last);
        column_t col;
        int      f;
        for (f = 0; f < 6; f++)
            col.data[f*IO_W +: IO_W] = rand_entry();
        col.last = last;
        return col;
    endfunction

    function logic [POS_VEC_W-1:0] rand_position();
        logic [63:0]          raw;
        logic [POS_VEC_W-1:0] pos;
        int                   s;
        int                   k;
        raw = {$urandom(), $urandom()};
        pos = raw[POS_VEC_W-1:0];
        if ($urandom_range(0, 1) == 0)
        begin
            for (k = 0; k < 3; k++)
            begin
                s = int'($urandom_range(0, 2 * SMALL_SPAN)) - SMALL_SPAN;
                pos[k*POS_W +: POS_W] = s[POS_W-1:0];
            end
        end
        return pos;
    endfunction

    task run_directed();
        column_t cols[6];
        int      n;
        cols[0] = '{last: 1'b0, data: '0};
        cols[1] = '{last: 1'b1, data: {6{24'h7FFFFF}}};
        cols[2] = '{last: 1'b0, data: {6{24'h800000}}};
        cols[3] = '{last: 1'b1, data: {{3{24'h800000}}, {3{24'h7FFFFF}}}};
        cols[4] = '{last: 1'b0, data: {{3{24'h7FFFFF}}, {3{24'h800000}}}};
        cols[5] = '{last: 1'b1, data: {3{24'hAAAAAA, 24'h555555}}};
        for (n = 0; n < 6; n++)
            send_column(cols[n]);
    endtask

    // Mostly whole Jacobians (a run of columns closed by last), some lone
    // columns with a random last flag, and runs cut short by the item budget.
    task run_random(int count);
        int left;
        int len;
        int j;
        left = count;
        while (left > 0)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_column(rand_column(1'($urandom_range(0, 1))));
                left--;
            end
            else
            begin
                len = $urandom_range(1, 12);
                for (j = 0; j < len && left > 0; j++)
                begin
                    send_column(rand_column(j == len - 1));
                    left--;
                end
            end
        end
    endtask

    task load_setting(logic [CFG_W-1:0] sel_val, logic [ROW_W-1:0] row,
                      logic [POS_VEC_W-1:0] body, logic [POS_VEC_W-1:0] origin);
        write_reg(CFG_FRAME_SELECT, sel_val);
        write_reg(CFG_ROT_ROW0, {9'h1FF, row});
        write_reg(CFG_ROT_ROW1, {9'h155, row});
        write_reg(CFG_ROT_ROW2, {9'h0AA, row});
        write_reg(CFG_BODY_POS, body);
        write_reg(CFG_REF_POS, origin);
        cfg_we <= 1'b0;
    endtask

    task load_random_setting(bit transform);
        logic [ROW_W-1:0] rows[3];
        cfg_idx_t         row_idx[3];
        int               m[3][3];
        int               perm[3];
        logic [63:0]      raw;
        real              ang;
        int               cs;
        int               sn;
        int               a;
        int               b;
        int               e;
        int               r;
        int               c;
        int               t;
        row_idx = '{CFG_ROT_ROW0, CFG_ROT_ROW1, CFG_ROT_ROW2};
        raw = {$urandom(), $urandom()};
        write_reg(($urandom_range(0, 1) == 0) ? CFG_SPARE_LO : CFG_SPARE_HI, raw[CFG_W-1:0]);
        for (r = 0; r < 3; r++)
            for (c = 0; c < 3; c++)
                m[r][c] = (r == c) ? 65536 : 0;
        case ($urandom_range(0, 3))
            0:
            begin
                perm = '{0, 1, 2};
                for (r = 2; r > 0; r--)
                begin
                    a = $urandom_range(0, r);
                    t = perm[r];
                    perm[r] = perm[a];
                    perm[a] = t;
                end
                for (r = 0; r < 3; r++)
                    for (c = 0; c < 3; c++)
                        m[r][c] = (c != perm[r]) ? 0 :
                                  ($urandom_range(0, 1) == 0) ? 65536 : -65536;
            end
            1:
            begin
                ang = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
                cs = $rtoi($cos(ang) * 65536.0);
                sn = $rtoi($sin(ang) * 65536.0);
                a = $urandom_range(0, 2);
                b = (a + 1) % 3;
                e = (a + 2) % 3;
                m[b][b] = cs;
                m[b][e] = -sn;
                m[e][b] = sn;
                m[e][e] = cs;
            end
            default:
                for (r = 0; r < 3; r++)
                    for (c = 0; c < 3; c++)
                        m[r][c] = int'($urandom_range(0, 262143)) - 131072;
        endcase
        for (r = 0; r < 3; r++)
            for (c = 0; c < 3; c++)
                rows[r][c*ROT_W +: ROT_W] = m[r][c][ROT_W-1:0];
        raw = {$urandom(), $urandom()};
        raw[0] = transform;
        write_reg(CFG_FRAME_SELECT, raw[CFG_W-1:0]);
        for (r = 0; r < 3; r++)
        begin
            raw = {$urandom(), $urandom()};
            write_reg(row_idx[r], {raw[CFG_W-1:ROW_W], rows[r]});
        end
        write_reg(CFG_BODY_POS, rand_position());
        write_reg(CFG_REF_POS, rand_position());
        cfg_we <= 1'b0;
    endtask

    // Output side: checks every item taken and stalls in short random bursts,
    // or for as long as the long hold-off below keeps rx_hold set.
    initial
    begin
        column_t got;
        int      stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tlast, m_axis_tdata};
                sb.check_result(got);
            end
            if (stall_left > 0)
                stall_left--;
            else if (idle_on && $urandom_range(0, 99) < idle_pct)
                stall_left = $urandom_range(1, 6);
            m_axis_tready <= !rx_hold && stall_left == 0;
        end
    end

    initial
    begin
        wait (sent_count >= HOLD_AT);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin
        int p;
        sb = new();
        idle_on = 1'b1;
        idle_pct = 20;
        sent_count = 0;
        rx_hold = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_FRAME_SELECT;
        cfg_data = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        settle();

        write_reg(CFG_FRAME_SELECT, 1);
        cfg_we <= 1'b0;
        run_directed();
        settle();

        load_setting({CFG_W{1'b1}}, {3{18'h1FFFF}}, {3{21'h0FFFFF}}, {3{21'h100000}});
        run_directed();
        settle();

        load_setting({{(CFG_W-1){1'b1}}, 1'b1} ^ 2, {3{18'h20000}},
                     {3{21'h100000}}, {3{21'h0FFFFF}});
        run_directed();
        settle();

        for (p = 0; p < 8; p++)
        begin
            if (p == 7)
                idle_on = 1'b0;
            idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            load_random_setting(p != 2 && p != 5);
            run_random(160);
            settle();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
